// ----- hw/rtl/swtm_pkg.sv -----
// Package for the sliding-window trimmed mean core: widths, defaults, state codes.
// No dependencies.
package swtm_pkg;
  localparam int unsigned WindowMaxDefault  = 64;
  localparam int unsigned SampleBitsDefault = 32;
  localparam int unsigned LatencyW = 32;
  localparam int unsigned AverageW = 40;
  localparam int unsigned KeptW    = 7;
  localparam int unsigned KRegW    = 7;
  localparam int unsigned XRegW    = 6;
  localparam logic [KRegW-1:0] KReset = 7'd8;
  localparam logic [XRegW-1:0] XReset = 6'd2;
  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] AddrKept    = 3'd0;
  localparam logic [CfgAddrW-1:0] AddrIgnored = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EV_RD, ST_EV_FIND, ST_EV_SHIFT, ST_INS, ST_INS_SHIFT,
    ST_SUM, ST_DIV, ST_OUT
  } eng_state_t;
endpackage

// ----- hw/rtl/swtm_if.sv -----
// Valid/ready channel interface with source and sink modports.
// Depends on nothing; width set by parameter.
interface swtm_if #(parameter int unsigned W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/swtm_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module swtm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/swtm_front.sv -----
// Front end: accepts readings, masks to sample width, queues them (2 entries).
// Depends on swtm_pkg.
module swtm_front #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [swtm_pkg::LatencyW-1:0]  in_latency,
  output logic                           q_valid,
  input  logic                           q_pop,
  output logic [SAMPLE_BITS-1:0]         q_data
);
  import swtm_pkg::*;
  logic [SAMPLE_BITS-1:0] buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= SAMPLE_BITS'(in_latency);
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ----- hw/rtl/swtm_engine.sv -----
// Back end: window upkeep in two RAMs, kept sum, restoring divider, result register.
// Depends on swtm_pkg and swtm_ram.
module swtm_engine #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [swtm_pkg::KRegW-1:0]    k_reg,
  input  logic [swtm_pkg::XRegW-1:0]    x_reg,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic [SAMPLE_BITS-1:0]        q_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swtm_pkg::AverageW-1:0] out_average,
  output logic                          out_average_valid,
  output logic [swtm_pkg::KeptW-1:0]    out_kept_number
);
  import swtm_pkg::*;
  localparam int unsigned AW = $clog2(WINDOW_MAX);
  localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SW = SAMPLE_BITS + CW;     // sum width
  localparam int unsigned DW = SW + 8;               // dividend width
  localparam int unsigned DCW = $clog2(DW + 1);

  eng_state_t state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt, idx_r, idx_nxt;
  logic [AW-1:0] old_r, old_nxt;
  logic [SAMPLE_BITS-1:0] val_r, val_nxt, hold_r, hold_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [CW:0]   rem_r, rem_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic          ov_r, ov_nxt;
  logic [AverageW-1:0] oavg_r, oavg_nxt;
  logic [KeptW-1:0] okept_r, okept_nxt;
  logic          rd_ok_r, rd_ok_nxt;

  // ram ports
  logic aw_we, sw_we;
  logic [AW-1:0] aw_wa, aw_ra, sw_wa, sw_ra;
  logic [SAMPLE_BITS-1:0] aw_wd, aw_rd, sw_wd, sw_rd;

  swtm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_arrival (
    .clk, .we(aw_we), .waddr(aw_wa), .wdata(aw_wd), .raddr(aw_ra), .rdata(aw_rd));
  swtm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_sorted (
    .clk, .we(sw_we), .waddr(sw_wa), .wdata(sw_wd), .raddr(sw_ra), .rdata(sw_rd));

  // effective K, X, window
  logic [CW:0] k_eff, x_eff, room, w_eff, xr;
  always_comb begin
    k_eff = (k_reg == '0) ? (CW+1)'(1) : (CW+1)'(k_reg);
    if (32'(k_reg) > WINDOW_MAX) k_eff = (CW+1)'(WINDOW_MAX);
    room  = (CW+1)'(WINDOW_MAX) - k_eff;
    xr    = (CW+1)'(x_reg);
    if (32'(x_reg) > 32'(room)) x_eff = room;
    else x_eff = xr;
    w_eff = k_eff + x_eff;
  end

  logic [CW:0] slot_sum;
  logic [AW-1:0] slot;
  logic [CW:0] rem_sh;
  always_comb begin
    slot_sum = (CW+1)'(old_r) + (CW+1)'(fill_r);
    slot = (slot_sum >= (CW+1)'(WINDOW_MAX)) ?
           AW'(slot_sum - (CW+1)'(WINDOW_MAX)) : AW'(slot_sum);
    rem_sh = {rem_r[CW-1:0], quo_r[DW-1]};
  end

  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r; idx_nxt = idx_r; old_nxt = old_r;
    val_nxt = val_r; hold_nxt = hold_r; sum_nxt = sum_r;
    quo_nxt = quo_r; rem_nxt = rem_r; dcnt_nxt = dcnt_r; kept_nxt = kept_r;
    ov_nxt = ov_r; oavg_nxt = oavg_r; okept_nxt = okept_r; rd_ok_nxt = 1'b0;
    q_pop = 1'b0;
    aw_we = 1'b0; aw_wa = slot; aw_wd = val_r; aw_ra = old_r;
    sw_we = 1'b0; sw_wa = AW'(idx_r); sw_wd = val_r; sw_ra = AW'(idx_r);
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1; val_nxt = q_data;
          if ((CW+1)'(fill_r) >= w_eff && fill_r != '0) state_nxt = ST_EV_RD;
          else begin
            state_nxt = ST_INS; idx_nxt = fill_r;
          end
        end
      end
      ST_EV_RD: begin
        // arrival read issued this cycle, data next
        aw_ra = old_r; idx_nxt = '0; state_nxt = ST_EV_FIND; rd_ok_nxt = 1'b0;
      end
      ST_EV_FIND: begin
        // scan sorted for first match; rd_ok_r marks sw_rd valid for idx_r
        if (!rd_ok_r) begin
          sw_ra = '0; idx_nxt = '0; rd_ok_nxt = 1'b1;
          hold_nxt = aw_rd;
        end else if (sw_rd == hold_r || idx_r + 1'b1 >= fill_r) begin
          // remove at idx_r: shift left
          state_nxt = ST_EV_SHIFT; sw_ra = AW'(idx_r + 1'b1); rd_ok_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 1'b1; sw_ra = AW'(idx_r + 1'b1); rd_ok_nxt = 1'b1;
        end
      end
      ST_EV_SHIFT: begin
        // read of idx+1 in flight; write it at idx when ready
        if (idx_r + 1'b1 >= fill_r) begin
          old_nxt = (32'(old_r) == WINDOW_MAX - 1) ? '0 : old_r + 1'b1;
          fill_nxt = fill_r - 1'b1;
          if ((CW+1)'(fill_r - 1'b1) >= w_eff && fill_r != CW'(1)) state_nxt = ST_EV_RD;
          else begin
            state_nxt = ST_INS; idx_nxt = fill_r - 1'b1;
          end
        end else if (!rd_ok_r) begin
          sw_ra = AW'(idx_r + 1'b1); rd_ok_nxt = 1'b1;
        end else begin
          sw_we = 1'b1; sw_wa = AW'(idx_r); sw_wd = sw_rd;
          idx_nxt = idx_r + 1'b1; sw_ra = AW'(idx_r + 2'd2); rd_ok_nxt = 1'b0;
        end
      end
      ST_INS: begin
        // write arrival, then insertion scan from top down
        aw_we = 1'b1;
        state_nxt = ST_INS_SHIFT; sw_ra = AW'(idx_r - 1'b1); rd_ok_nxt = 1'b0;
      end
      ST_INS_SHIFT: begin
        if (idx_r == '0) begin
          sw_we = 1'b1; sw_wa = '0; sw_wd = val_r; state_nxt = ST_SUM;
          fill_nxt = fill_r + 1'b1;
        end else if (!rd_ok_r) begin
          sw_ra = AW'(idx_r - 1'b1); rd_ok_nxt = 1'b1;
        end else if (sw_rd > val_r) begin
          sw_we = 1'b1; sw_wa = AW'(idx_r); sw_wd = sw_rd;
          idx_nxt = idx_r - 1'b1; rd_ok_nxt = 1'b0;
        end else begin
          sw_we = 1'b1; sw_wa = AW'(idx_r); sw_wd = val_r; state_nxt = ST_SUM;
          fill_nxt = fill_r + 1'b1;
        end
        if (state_nxt == ST_SUM) begin
          kept_nxt = ((CW+1)'(fill_r + 1'b1) > x_eff) ?
                     CW'((CW+1)'(fill_r + 1'b1) - x_eff) : '0;
          idx_nxt = '0; sum_nxt = '0;
        end
      end
      ST_SUM: begin
        if (idx_r >= kept_r) begin
          state_nxt = ST_DIV; quo_nxt = {sum_r, 8'd0}; rem_nxt = '0;
          dcnt_nxt = DCW'(DW);
        end else if (!rd_ok_r) begin
          sw_ra = AW'(idx_r); rd_ok_nxt = 1'b1;
        end else begin
          sum_nxt = sum_r + SW'(sw_rd); idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (kept_r == '0) begin
          quo_nxt = '0; state_nxt = ST_OUT;
        end else if (dcnt_r == '0) state_nxt = ST_OUT;
        else begin
          dcnt_nxt = dcnt_r - 1'b1;
          if (rem_sh >= (CW+1)'(kept_r)) begin
            rem_nxt = rem_sh - (CW+1)'(kept_r); quo_nxt = {quo_r[DW-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh; quo_nxt = {quo_r[DW-2:0], 1'b0};
          end
        end
      end
      ST_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; oavg_nxt = AverageW'(quo_r);
          okept_nxt = KeptW'(kept_r); state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; fill_r <= '0; old_r <= '0; ov_r <= 1'b0; rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt; fill_r <= fill_nxt; old_r <= old_nxt; ov_r <= ov_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
    idx_r <= idx_nxt; val_r <= val_nxt; hold_r <= hold_nxt;
    sum_r <= sum_nxt; quo_r <= quo_nxt; rem_r <= rem_nxt; dcnt_r <= dcnt_nxt;
    kept_r <= kept_nxt; oavg_r <= oavg_nxt; okept_r <= okept_nxt;
  end

  assign out_valid = ov_r;
  assign out_average = oavg_r;
  assign out_kept_number = okept_r;
  assign out_average_valid = (okept_r != '0);
endmodule

// ----- hw/rtl/sliding_window_trimmed_mean_core.sv -----
// Top level: APB register file, front queue and back-end engine.
// Depends on swtm_pkg, swtm_if, swtm_front, swtm_engine.
//
//  channel | dir | handshake         | payload
//  in      | in  | in_valid/ready    | latency[31:0]
//  out     | out | out_valid/ready   | average[39:0], average_valid, kept_number[6:0]
//  cfg     | in  | APB psel/penable  | kept_count_target @0, ignored_count @4
//
// Per item: a pop, eviction (arrival read, sorted scan, shift), insertion, the kept
// sum, the divider and an output step. The divider dominates small windows, the
// single-read sorted RAM large ones.
// rst_n is synchronous; a full 2-deep input queue stalls the input, an untaken
// result holds the back end in its output state.
module sliding_window_trimmed_mean_core #(
  parameter int unsigned WINDOW_MAX  = swtm_pkg::WindowMaxDefault,
  parameter int unsigned SAMPLE_BITS = swtm_pkg::SampleBitsDefault
) (
  input  logic clk,
  input  logic rst_n,
  swtm_if.sink   in_ch,
  swtm_if.source out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [swtm_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import swtm_pkg::*;
  logic [KRegW-1:0] k_r;
  logic [XRegW-1:0] x_r;
  logic q_valid, q_pop;
  logic [SAMPLE_BITS-1:0] q_data;
  logic [AverageW-1:0] avg;
  logic avg_v;
  logic [KeptW-1:0] kn;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= KReset; x_r <= XReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == AddrKept) k_r <= cfg_pwdata[KRegW-1:0];
      else if (cfg_paddr == AddrIgnored) x_r <= cfg_pwdata[XRegW-1:0];
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == AddrKept) cfg_prdata = 32'(k_r);
    else if (cfg_paddr == AddrIgnored) cfg_prdata = 32'(x_r);
  end

  swtm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_latency(in_ch.data), .q_valid, .q_pop, .q_data);

  swtm_engine #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_engine (
    .clk, .rst_n, .k_reg(k_r), .x_reg(x_r), .q_valid, .q_pop, .q_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_average(avg),
    .out_average_valid(avg_v), .out_kept_number(kn));

  assign out_ch.data = {kn, avg_v, avg};
endmodule
